// ===== rtl/relb_pkg.sv =====
package relb_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int ADDR_W = 32;
	localparam int SIZE_W = 16;
	localparam int OFFS_W = 20;
	localparam int SLOT_OUT_W = 4;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_FIND = 1'b1;

	typedef struct packed {
		logic accept;      // item taken: latch fields, prime the walk
		logic add_commit;  // store entry, move pointers, load result
		logic walk_step;   // advance the walk by one entry
		logic finish;      // load find result
	} cmd_t;

	typedef struct packed {
		logic out_free;    // output register empty or being emptied
		logic walk_done;   // walk hit or ran out of entries
	} sts_t;

	typedef struct packed {
		logic                  is_full;
		logic [SIZE_W-1:0]     byte_offset;
		logic [SIZE_W-1:0]     hit_size;
		logic [ADDR_W-1:0]     hit_address;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  found;
	} res_t;

endpackage

// ===== rtl/relb_ctrl.sv =====
module relb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_op,
	output logic          in_ready,
	input  relb_pkg::sts_t sts,
	output relb_pkg::cmd_t cmd
);
	import relb_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ADD  = 2'd1;
	localparam logic [1:0] ST_WALK = 2'd2;

	logic [1:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = (in_op == OP_FIND) ? ST_WALK : ST_ADD;
				end
			end
			ST_ADD: begin
				if (sts.out_free) begin
					cmd.add_commit = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_WALK: begin
				if (sts.walk_done) begin
					if (sts.out_free) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/relb_dp.sv =====
module relb_dp #(
	parameter int DEPTH = relb_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  relb_pkg::cmd_t               cmd,
	output relb_pkg::sts_t               sts,
	input  logic [relb_pkg::ADDR_W-1:0]  entry_address,
	input  logic [relb_pkg::SIZE_W-1:0]  entry_size,
	input  logic [relb_pkg::OFFS_W-1:0]  lookup_offs,
	output logic                         out_valid,
	input  logic                         out_ready,
	output relb_pkg::res_t               res
);
	import relb_pkg::*;

	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	function automatic logic [SLOT_W-1:0] nxt(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
		logic [SLOT_W+SLOT_OUT_W-1:0] ext;
		ext = {{SLOT_OUT_W{1'b0}}, s};
		return ext[SLOT_OUT_W-1:0];
	endfunction

	logic [ADDR_W-1:0] addr_mem [DEPTH];
	logic [SIZE_W-1:0] size_mem [DEPTH];

	logic [SLOT_W-1:0] wr_q, rd_q;
	logic              full_q;

	logic [ADDR_W-1:0] lat_addr_q;
	logic [SIZE_W-1:0] lat_size_q;

	logic [SLOT_W-1:0] walk_idx_q;
	logic [CNT_W-1:0]  remain_q;
	logic [OFFS_W-1:0] offs_q;

	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [SIZE_W-1:0] sz_s1;

	logic              out_valid_q;
	res_t              res_q;

	logic [SLOT_W:0]   diff;
	logic [CNT_W-1:0]  used;
	logic              hit;
	logic [SLOT_W-1:0] wr_nx, rd_nx;

	always_comb begin
		diff = {1'b0, wr_q} - {1'b0, rd_q};
		if (wr_q < rd_q) begin
			diff = diff + (SLOT_W + 1)'(DEPTH);
		end
		used = full_q ? CNT_W'(DEPTH) : CNT_W'(diff);
	end

	assign hit   = vld_s1 && (remain_q != '0) && (offs_q < {{(OFFS_W-SIZE_W){1'b0}}, sz_s1});
	assign wr_nx = nxt(wr_q);
	assign rd_nx = full_q ? nxt(rd_q) : rd_q;

	assign sts.walk_done = (remain_q == '0) || hit;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign res           = res_q;

	// entry store, single write port, registered read along the walk
	always_ff @(posedge clk) begin
		if (cmd.add_commit) begin
			addr_mem[wr_q] <= lat_addr_q;
			size_mem[wr_q] <= lat_size_q;
		end
		if (cmd.walk_step) begin
			addr_s1 <= addr_mem[walk_idx_q];
			sz_s1   <= size_mem[walk_idx_q];
			idx_s1  <= walk_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			full_q      <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				vld_s1 <= 1'b0;
			end else if (cmd.walk_step) begin
				vld_s1 <= 1'b1;
			end
			if (cmd.add_commit) begin
				wr_q   <= wr_nx;
				rd_q   <= rd_nx;
				full_q <= full_q || (wr_nx == rd_nx);
			end
			if (cmd.add_commit || cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lat_addr_q <= entry_address;
			lat_size_q <= entry_size;
			offs_q     <= lookup_offs;
			walk_idx_q <= rd_q;
			remain_q   <= used;
		end else if (cmd.walk_step) begin
			walk_idx_q <= nxt(walk_idx_q);
			// the entry now in stage 1 missed: step past it
			if (vld_s1) begin
				offs_q   <= offs_q - {{(OFFS_W-SIZE_W){1'b0}}, sz_s1};
				remain_q <= remain_q - 1'b1;
			end
		end
		if (cmd.add_commit) begin
			res_q.found       <= 1'b0;
			res_q.slot        <= slot_out(wr_q);
			res_q.hit_address <= '0;
			res_q.hit_size    <= '0;
			res_q.byte_offset <= '0;
			res_q.is_full     <= full_q || (wr_nx == rd_nx);
		end else if (cmd.finish) begin
			res_q.found       <= hit;
			res_q.slot        <= hit ? slot_out(idx_s1) : '0;
			res_q.hit_address <= hit ? addr_s1 : '0;
			res_q.hit_size    <= hit ? sz_s1 : '0;
			res_q.byte_offset <= hit ? offs_q[SIZE_W-1:0] : '0;
			res_q.is_full     <= full_q;
		end
	end

`ifndef SYNTHESIS
	a_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (wr_q == rd_q))
		else $error("full ring with pointers apart");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.add_commit || cmd.finish) |-> sts.out_free)
		else $error("result loaded over a pending one");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.add_commit || cmd.finish) |=> out_valid_q)
		else $error("result loaded but not presented");

	a_add_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_commit |=> !res_q.found)
		else $error("add reported a hit");
`endif

endmodule

// ===== rtl/ring_entry_buffer_offset_lookup.sv =====
// Channel  Dir  tdata (low bit up)                                     tuser
// s_axis   in   entry_address[31:0] entry_size[47:32] lookup_offs[67:48] operation
// m_axis   out  slot[3:0] hit_address[35:4] hit_size[51:36]              found
//               byte_offset[67:52] is_full[68]
//
// Add: an accept step, then a commit step. Find: accept, then the
// entry store is read once per cycle along the ring until a hit or the end.
// Commit or find completion holds while the output register still waits.
// One item in flight; the next item is taken while its result waits in the
// output register. Reset empties the ring; store contents are not cleared.
module ring_entry_buffer_offset_lookup #(
	parameter int DEPTH = relb_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,   // entry_address, entry_size, lookup_offs
	input  logic        s_axis_tuser,   // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // slot, hit_address, hit_size, byte_offset, is_full
	output logic        m_axis_tuser    // found
);
	import relb_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t res;

	relb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	relb_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.entry_address (s_axis_tdata[31:0]),
		.entry_size    (s_axis_tdata[47:32]),
		.lookup_offs   (s_axis_tdata[67:48]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.res           (res)
	);

	assign m_axis_tuser = res.found;
	assign m_axis_tdata = {3'b000, res.is_full, res.byte_offset, res.hit_size,
		res.hit_address, res.slot};

endmodule

// ===== verif/testbench.sv =====
module testbench;
	import relb_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PCT = 34;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;   // entry_address, entry_size, lookup_offs
	logic        s_axis_tuser;   // operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;   // slot, hit_address, hit_size, byte_offset, is_full
	logic        m_axis_tuser;   // found

	// shadow copy of the ring
	logic [ADDR_W-1:0] ring_addr [DEPTH];
	logic [SIZE_W-1:0] ring_size [DEPTH];
	int                wr_ptr;
	int                rd_ptr;
	bit                ring_full;

	res_t lookup_results [$];
	int   mismatches = 0;
	bit   steady;
	int   quiet_cycles = 0;

	ring_entry_buffer_offset_lookup #(.DEPTH(DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int entries_held();
		return ring_full ? DEPTH : (wr_ptr + DEPTH - rd_ptr) % DEPTH;
	endfunction

	function automatic int stored_bytes();
		int total;
		int idx;
		total = 0;
		idx = rd_ptr;
		for (int n = 0; n < entries_held(); n++) begin
			total += ring_size[idx];
			idx = (idx + 1) % DEPTH;
		end
		return total;
	endfunction

	// updates the shadow ring and returns the result the block should give
	function automatic res_t ring_apply(input logic op, input logic [ADDR_W-1:0] addr,
			input logic [SIZE_W-1:0] size, input logic [OFFS_W-1:0] offs);
		res_t r;
		int   rem;
		int   idx;
		int   held;
		bit   hit;
		r = '0;
		if (op == OP_ADD) begin
			r.slot = wr_ptr[SLOT_OUT_W-1:0];
			ring_addr[wr_ptr] = addr;
			ring_size[wr_ptr] = size;
			if (ring_full)
				rd_ptr = (rd_ptr + 1) % DEPTH;
			wr_ptr = (wr_ptr + 1) % DEPTH;
			if (wr_ptr == rd_ptr)
				ring_full = 1'b1;
		end else begin
			held = entries_held();
			rem = offs;
			idx = rd_ptr;
			hit = 1'b0;
			for (int n = 0; n < held && !hit; n++) begin
				if (rem < ring_size[idx]) begin
					hit = 1'b1;
					r.found = 1'b1;
					r.slot = idx[SLOT_OUT_W-1:0];
					r.hit_address = ring_addr[idx];
					r.hit_size = ring_size[idx];
					r.byte_offset = rem[SIZE_W-1:0];
				end else begin
					rem -= ring_size[idx];
					idx = (idx + 1) % DEPTH;
				end
			end
		end
		r.is_full = ring_full;
		return r;
	endfunction

	task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr,
			input logic [SIZE_W-1:0] size, input logic [OFFS_W-1:0] offs);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 72'({$urandom, $urandom, $urandom});
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {4'b0, offs, size, addr};
		do
			@(posedge clk);
		while (!s_axis_tready);
		lookup_results.push_back(ring_apply(op, addr, size, offs));
	endtask

	task automatic push_entry(input logic [ADDR_W-1:0] addr, input logic [SIZE_W-1:0] size);
		send_item(OP_ADD, addr, size, 20'($urandom));
	endtask

	task automatic find_offset(input logic [OFFS_W-1:0] offs);
		send_item(OP_FIND, $urandom, 16'($urandom), offs);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (lookup_results.size() != 0)
			@(posedge clk);
	endtask

	// half adds of random size; finds at offsets mostly inside the stored data, some near its end, some anywhere
	task automatic random_item();
		int total;
		int pick;
		int sz;
		int near;
		pick = $urandom_range(99);
		if (pick < 50) begin
			pick = $urandom_range(99);
			if (pick < 20)
				sz = 0;
			else if (pick < 65)
				sz = $urandom_range(8);
			else if (pick < 80)
				sz = $urandom_range(1000);
			else
				sz = $urandom_range(65535);
			push_entry($urandom, sz[SIZE_W-1:0]);
		end else begin
			total = stored_bytes();
			pick = $urandom_range(99);
			if (pick < 60 && total > 0) begin
				find_offset(20'($urandom_range(total - 1)));
			end else if (pick < 75) begin
				near = total + $urandom_range(2) - 1;
				if (near < 0)
					near = 0;
				find_offset(near[OFFS_W-1:0]);
			end else begin
				find_offset(20'($urandom));
			end
		end
	endtask

	task automatic test_empty_ring();
		find_offset('0);
		find_offset('1);
	endtask

	// zero-size entries at the head and in the middle must be stepped over
	task automatic test_partial_ring();
		push_entry(32'h0000_0000, 16'd0);
		push_entry(32'hFFFF_FFFF, 16'd1);
		push_entry(32'hA5A5_5A5A, 16'hFFFF);
		push_entry(32'h5A5A_A5A5, 16'd0);
		push_entry(32'h1234_5678, 16'd7);
		find_offset(20'd0);
		find_offset(20'd1);
		find_offset(20'd65536);
		find_offset(20'd65542);
		find_offset(20'd65543);
	endtask

	task automatic test_wrap_overwrite();
		for (int i = 0; i < DEPTH - 5; i++)
			push_entry($urandom, 16'(i + 2));
		// ring now full: this add drops the oldest entry
		push_entry(32'hDEAD_BEEF, 16'd3);
		find_offset(20'd0);
		find_offset(20'(stored_bytes() - 1));
	endtask

	task automatic test_drain_pause();
		repeat (20)
			random_item();
		wait_drained();
		repeat (20)
			random_item();
		wait_drained();
	endtask

	task automatic test_random_traffic();
		steady = 1'b1;
		for (int i = 0; i < 1490; i++) begin
			if (i == 300)
				steady = 1'b0;
			random_item();
		end
	endtask

	always @(negedge clk)
		m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (lookup_results.size() == 0) begin
				$error("result with no lookup pending: tdata %h found %b",
					m_axis_tdata, m_axis_tuser);
				mismatches++;
			end else begin
				exp_r = lookup_results.pop_front();
				if (m_axis_tuser !== exp_r.found) begin
					$error("found: expected %b, got %b", exp_r.found, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[3:0] !== exp_r.slot) begin
					$error("slot: expected %0d, got %0d", exp_r.slot, m_axis_tdata[3:0]);
					mismatches++;
				end
				if (m_axis_tdata[35:4] !== exp_r.hit_address) begin
					$error("hit_address: expected %h, got %h", exp_r.hit_address,
						m_axis_tdata[35:4]);
					mismatches++;
				end
				if (m_axis_tdata[51:36] !== exp_r.hit_size) begin
					$error("hit_size: expected %0d, got %0d", exp_r.hit_size,
						m_axis_tdata[51:36]);
					mismatches++;
				end
				if (m_axis_tdata[67:52] !== exp_r.byte_offset) begin
					$error("byte_offset: expected %0d, got %0d", exp_r.byte_offset,
						m_axis_tdata[67:52]);
					mismatches++;
				end
				if (m_axis_tdata[68] !== exp_r.is_full) begin
					$error("is_full: expected %b, got %b", exp_r.is_full, m_axis_tdata[68]);
					mismatches++;
				end
			end
		end
	end

	// no item moving on either side for too long means the block has hung
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		steady = 1'b0;
		wr_ptr = 0;
		rd_ptr = 0;
		ring_full = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = OP_ADD;
		s_axis_tdata = '0;
		arst_n = 1'b0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_ring();
		test_partial_ring();
		test_wrap_overwrite();
		test_drain_pause();
		test_random_traffic();

		wait_drained();
		repeat (DEPTH + 8)
			@(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
